@@ design/ibre_pkg.sv @@
// Shared constants, codes and bundle types of the in-place block rotate engine.
package ibre_pkg;

	localparam int DEPTH  = 1024;
	localparam int WORD_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_ROTATE = 2'd2;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic              go;
		logic [ADDR_W-1:0] base;
		logic [CNT_W-1:0]  size;
		logic [CNT_W-1:0]  shift;
	} rot_cmd_t;

endpackage

@@ design/ibre_mem.sv @@
// Word store: one write port and one registered read port.
module ibre_mem (
	input  logic                       clk,
	input  ibre_pkg::mem_req_t         req,
	output logic [ibre_pkg::WORD_W-1:0] rdata
);

	logic [ibre_pkg::WORD_W-1:0] store_q [ibre_pkg::DEPTH];
	logic [ibre_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			store_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= store_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/ibre_rot.sv @@
// Cycle-leader rotation sequencer with one shared modular step adder.
module ibre_rot (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ibre_pkg::rot_cmd_t          cmd,
	input  logic [ibre_pkg::WORD_W-1:0] rdata,
	output ibre_pkg::mem_req_t          req,
	output logic                        done
);

	typedef enum logic [4:0] {
		R_IDLE    = 5'b00001,
		R_LEAD_RD = 5'b00010,
		R_LEAD_WT = 5'b00100,
		R_STEP_RD = 5'b01000,
		R_STEP_WR = 5'b10000
	} rot_state_t;

	rot_state_t                   state_q;
	logic [ibre_pkg::ADDR_W-1:0] base_q;
	logic [ibre_pkg::CNT_W-1:0]  size_q;
	logic [ibre_pkg::CNT_W-1:0]  shift_q;
	logic [ibre_pkg::ADDR_W-1:0] leader_q;
	logic [ibre_pkg::ADDR_W-1:0] pos_q;
	logic [ibre_pkg::ADDR_W-1:0] next_q;
	logic [ibre_pkg::CNT_W-1:0]  moved_q;
	logic [ibre_pkg::WORD_W-1:0] carry_q;
	logic                        done_q;

	logic [ibre_pkg::SUM_W-1:0]  step_sum;
	logic [ibre_pkg::ADDR_W-1:0] step_next;
	logic                        last_word;

	// Next position in the zone: pos + shift, wrapped once.
	always_comb begin
		step_sum = ibre_pkg::SUM_W'(pos_q) + ibre_pkg::SUM_W'(shift_q);
		if (step_sum >= ibre_pkg::SUM_W'(size_q)) begin
			step_sum = step_sum - ibre_pkg::SUM_W'(size_q);
		end
		step_next = step_sum[ibre_pkg::ADDR_W-1:0];
	end

	assign last_word = (moved_q + ibre_pkg::CNT_W'(1)) == size_q;

	always_comb begin
		req       = '0;
		req.wdata = carry_q;
		req.waddr = base_q + next_q;
		unique case (state_q)
			R_LEAD_RD: begin
				req.re    = 1'b1;
				req.raddr = base_q + leader_q;
			end
			R_STEP_RD: begin
				req.re    = 1'b1;
				req.raddr = base_q + step_next;
			end
			R_STEP_WR: begin
				req.we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (cmd.go) begin
						state_q <= R_LEAD_RD;
					end
				end
				R_LEAD_RD: state_q <= R_LEAD_WT;
				R_LEAD_WT: state_q <= R_STEP_RD;
				R_STEP_RD: state_q <= R_STEP_WR;
				R_STEP_WR: begin
					if (next_q == leader_q) begin
						if (last_word) begin
							done_q  <= 1'b1;
							state_q <= R_IDLE;
						end else begin
							state_q <= R_LEAD_RD;
						end
					end else begin
						state_q <= R_STEP_RD;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				base_q   <= cmd.base;
				size_q   <= cmd.size;
				shift_q  <= cmd.shift;
				leader_q <= '0;
				moved_q  <= '0;
			end
			R_LEAD_RD: pos_q <= leader_q;
			R_LEAD_WT: carry_q <= rdata;
			R_STEP_RD: next_q <= step_next;
			R_STEP_WR: begin
				// Drop the carried word in place, pick up the one it displaced.
				carry_q <= rdata;
				pos_q   <= next_q;
				moved_q <= moved_q + ibre_pkg::CNT_W'(1);
				if (next_q == leader_q) begin
					leader_q <= leader_q + ibre_pkg::ADDR_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;

endmodule

@@ design/in_place_block_rotate_engine.sv @@
// Top level of the in-place block rotate engine: request decode, checks and result.
//
//  channel   handshake             word carried
//  -------   ---------------------  -------------------------------------------
//  request   start & !busy          op, word_address, write_word, dest_index,
//                                   source_index, move_length
//  result    done (one-cycle pulse) read_word, status
//
// A write is done in T_EXEC and a read passes through T_RDWAIT before the result
// strobe; a rejected or out-of-range move ends in T_EXEC. A move that rotates a zone
// of N words in g = gcd(N, shift) chains runs in T_ROT: each
// word costs one read and one write on the single pair of memory ports.
// Reset clears only control state; the word store holds garbage until written.
// busy stays high from acceptance until the result strobe; the strobe is
// shown once and is not held, since the receiver cannot stall.
module in_place_block_rotate_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [9:0]  word_address,
	input  logic [31:0] write_word,
	input  logic [10:0] dest_index,
	input  logic [9:0]  source_index,
	input  logic [10:0] move_length,
	output logic        done,
	output logic [31:0] read_word,
	output logic [1:0]  status
);

	typedef enum logic [3:0] {
		T_IDLE   = 4'b0001,
		T_EXEC   = 4'b0010,
		T_RDWAIT = 4'b0100,
		T_ROT    = 4'b1000
	} top_state_t;

	top_state_t  state_q;
	logic [1:0]  op_q;
	logic [9:0]  addr_q;
	logic [31:0] wword_q;
	logic [10:0] dst_q;
	logic [9:0]  src_q;
	logic [10:0] len_q;

	logic        done_q;
	logic [31:0] read_word_q;
	logic [1:0]  status_q;

	ibre_pkg::mem_req_t              mem_req;
	ibre_pkg::mem_req_t              rot_req;
	ibre_pkg::rot_cmd_t              rot_cmd;
	logic [ibre_pkg::WORD_W-1:0]     mem_rdata;
	logic                            rot_done;

	// Move checks, on the latched request.
	logic [ibre_pkg::SUM_W-1:0] src_w;
	logic [ibre_pkg::SUM_W-1:0] dst_w;
	logic [ibre_pkg::SUM_W-1:0] len_w;
	logic [ibre_pkg::SUM_W-1:0] end_w;
	logic                       mv_reject;
	logic                       mv_range;
	logic                       addr_ok;

	assign busy = (state_q != T_IDLE);

	always_comb begin
		src_w = ibre_pkg::SUM_W'(src_q);
		dst_w = ibre_pkg::SUM_W'(dst_q);
		len_w = ibre_pkg::SUM_W'(len_q);
		end_w = src_w + len_w;
		// Empty block, no displacement, or destination strictly inside the block.
		mv_reject = (len_w == '0) || (src_w == dst_w) || ((dst_w > src_w) && (dst_w < end_w));
		mv_range  = (src_w >= ibre_pkg::SUM_W'(ibre_pkg::DEPTH))
		         || (dst_w > ibre_pkg::SUM_W'(ibre_pkg::DEPTH))
		         || (end_w > ibre_pkg::SUM_W'(ibre_pkg::DEPTH));
		addr_ok   = (32'(addr_q) < ibre_pkg::DEPTH);
	end

	// Zone of the rotation: moving down rotates [dst, src+len) by len, moving
	// up rotates [src, dst) by the distance past the block.
	always_comb begin
		rot_cmd = '0;
		if (dst_w < src_w) begin
			rot_cmd.base  = dst_w[ibre_pkg::ADDR_W-1:0];
			rot_cmd.size  = ibre_pkg::CNT_W'(end_w - dst_w);
			rot_cmd.shift = ibre_pkg::CNT_W'(len_w);
		end else begin
			rot_cmd.base  = src_w[ibre_pkg::ADDR_W-1:0];
			rot_cmd.size  = ibre_pkg::CNT_W'(dst_w - src_w);
			rot_cmd.shift = ibre_pkg::CNT_W'(dst_w - end_w);
		end
		rot_cmd.go = (state_q == T_EXEC) && (op_q == ibre_pkg::OP_ROTATE)
		          && !mv_reject && !mv_range && (rot_cmd.shift != '0);
	end

	// Memory port: the rotator owns it during a move, the decoder otherwise.
	always_comb begin
		mem_req       = '0;
		mem_req.waddr = addr_q[ibre_pkg::ADDR_W-1:0];
		mem_req.raddr = addr_q[ibre_pkg::ADDR_W-1:0];
		mem_req.wdata = wword_q[ibre_pkg::WORD_W-1:0];
		if (state_q == T_ROT) begin
			mem_req = rot_req;
		end else if (state_q == T_EXEC && addr_ok) begin
			mem_req.we = (op_q == ibre_pkg::OP_WRITE);
			mem_req.re = (op_q == ibre_pkg::OP_READ);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (start) begin
						state_q <= T_EXEC;
					end
				end
				T_EXEC: begin
					if (op_q == ibre_pkg::OP_READ && addr_ok) begin
						state_q <= T_RDWAIT;
					end else if (rot_cmd.go) begin
						state_q <= T_ROT;
					end else begin
						done_q  <= 1'b1;
						state_q <= T_IDLE;
					end
				end
				T_RDWAIT: begin
					done_q  <= 1'b1;
					state_q <= T_IDLE;
				end
				T_ROT: begin
					if (rot_done) begin
						done_q  <= 1'b1;
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// Request capture and result words.
	always_ff @(posedge clk) begin
		if (state_q == T_IDLE && start) begin
			op_q    <= op;
			addr_q  <= word_address;
			wword_q <= write_word;
			dst_q   <= dest_index;
			src_q   <= source_index;
			len_q   <= move_length;
		end
		unique case (state_q)
			T_EXEC: begin
				read_word_q <= '0;
				unique case (op_q)
					ibre_pkg::OP_WRITE,
					ibre_pkg::OP_READ: status_q <= addr_ok ? ibre_pkg::ST_DONE
					                                      : ibre_pkg::ST_RANGE;
					ibre_pkg::OP_ROTATE: begin
						if (mv_reject) begin
							status_q <= ibre_pkg::ST_REJECT;
						end else if (mv_range) begin
							status_q <= ibre_pkg::ST_RANGE;
						end else begin
							status_q <= ibre_pkg::ST_DONE;
						end
					end
					default: status_q <= ibre_pkg::ST_REJECT;
				endcase
			end
			T_RDWAIT: read_word_q <= 32'(mem_rdata);
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign read_word = read_word_q;
	assign status    = status_q;

	ibre_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	ibre_rot u_rot (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rot_cmd),
		.rdata  (mem_rdata),
		.req    (rot_req),
		.done   (rot_done)
	);

endmodule

@@ bench/in_place_block_rotate_engine_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the in-place block rotate engine: scoreboard mirror and request driver.
module in_place_block_rotate_engine_tb;
	import ibre_pkg::*;

	// The request port carries two bits of op, so the fourth code reaches the block too.
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	// Words in the busy window that most random requests aim at, so moves shuffle live data.
	localparam int FOCUS = 64;
	// Far above 300 requests that each rotate the whole store through its
	// slowest chain pattern, plus the sender's longest gaps.
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int ITEMS_PER_PHASE = 86;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [1:0]        code;
	} outcome_t;

	// Mirror of the word store plus a written flag per word; predicts one result word
	// per accepted request word and checks results in order.
	class rotate_scoreboard;
		logic [WORD_W-1:0] mirror [DEPTH];
		bit                written [DEPTH];
		outcome_t          expected_q [$];
		int                errors;

		// Rotate [base, base+size): the word at offset p lands at offset (p+shift) mod size.
		function void rotate_zone(int base, int size, int shift);
			logic [WORD_W-1:0] held_word [DEPTH];
			bit                held_flag [DEPTH];
			for (int p = 0; p < size; p++) begin
				held_word[p] = mirror[base + p];
				held_flag[p] = written[base + p];
			end
			for (int p = 0; p < size; p++) begin
				mirror[base + (p + shift) % size]  = held_word[p];
				written[base + (p + shift) % size] = held_flag[p];
			end
		endfunction

		function void note_request(logic [1:0] req_op, logic [9:0] addr, logic [31:0] data,
				logic [10:0] dst_in, logic [9:0] src_in, logic [10:0] len_in);
			outcome_t r;
			int       dst;
			int       src;
			int       len;
			dst    = int'(dst_in);
			src    = int'(src_in);
			len    = int'(len_in);
			r.word = '0;
			case (req_op)
				OP_WRITE: begin
					if (int'(addr) < DEPTH) begin
						mirror[addr]  = data[WORD_W-1:0];
						written[addr] = 1'b1;
						r.code        = ST_DONE;
					end else begin
						r.code = ST_RANGE;
					end
				end
				OP_READ: begin
					if (int'(addr) < DEPTH) begin
						r.word = mirror[addr];
						r.code = ST_DONE;
					end else begin
						r.code = ST_RANGE;
					end
				end
				OP_ROTATE: begin
					// Reject before the range test: empty block, no move, or landing
					// strictly inside the block itself.
					if (len == 0 || src == dst || (dst > src && dst < src + len)) begin
						r.code = ST_REJECT;
					end else if (src >= DEPTH || dst > DEPTH || src + len > DEPTH) begin
						r.code = ST_RANGE;
					end else begin
						if (dst < src)
							rotate_zone(dst, src + len - dst, len);
						else
							rotate_zone(src, dst - src, dst - src - len);
						r.code = ST_DONE;
					end
				end
				default: r.code = ST_REJECT;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [31:0] word, logic [1:0] code);
			outcome_t r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word: read_word %h status %0d",
					$time, word, code);
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (word !== r.word) begin
				$display("%0t: read_word expected %h actual %h", $time, r.word, word);
				errors++;
			end
			if (code !== r.code) begin
				$display("%0t: status expected %0d actual %0d", $time, r.code, code);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = OP_WRITE;
	logic [9:0]  word_address = '0;
	logic [31:0] write_word = '0;
	logic [10:0] dest_index = '0;
	logic [9:0]  source_index = '0;
	logic [10:0] move_length = '0;
	logic        done;
	logic [31:0] read_word;
	logic [1:0]  status;

	rotate_scoreboard sb;
	int               sender_idle_pct = 0;
	int               cycle_count = 0;

	in_place_block_rotate_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.word_address (word_address),
		.write_word   (write_word),
		.dest_index   (dest_index),
		.source_index (source_index),
		.move_length  (move_length),
		.done         (done),
		.read_word    (read_word),
		.status       (status)
	);

	always #5 clk = ~clk;

	// Bound the run; a hung handshake ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("in_place_block_rotate_engine_tb: errors");
			$finish;
		end
	end

	// The strobe lasts one cycle and cannot be held off: take every result word at its edge.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(read_word, status);
	end

	// Present one request word and hold it until an edge sees start high with busy low.
	// Called at a rising edge; returns at the accepting edge with start still high.
	task automatic issue_request(logic [1:0] req_op, logic [9:0] addr, logic [31:0] data,
			logic [10:0] dst, logic [9:0] src, logic [10:0] len);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		op           <= req_op;
		word_address <= addr;
		write_word   <= data;
		dest_index   <= dst;
		source_index <= src;
		move_length  <= len;
		start        <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_request(req_op, addr, data, dst, src, len);
	endtask

	// Drop start and hold off until every predicted result word has come back.
	task automatic drain_results();
		start <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// One random request word: mostly live traffic in the focus window, some whole-store
	// moves, raw move fields that mostly trip the reject or range checks, and the unused op.
	task automatic random_item();
		logic [1:0]  req_op;
		logic [9:0]  addr;
		logic [31:0] data;
		logic [10:0] dst;
		logic [9:0]  src;
		logic [10:0] len;
		int          pick;
		int          span;
		int          n;
		int          s;
		bit          found;
		// Fields that the chosen op does not use carry noise.
		req_op = OP_WRITE;
		addr   = 10'($urandom);
		data   = $urandom;
		dst    = 11'($urandom);
		src    = 10'($urandom);
		len    = 11'($urandom);
		pick   = $urandom_range(99);
		if (pick < 35) begin
			if ($urandom_range(9) != 0)
				addr = 10'($urandom_range(FOCUS - 1));
		end else if (pick < 65) begin
			// Read only words that hold written data; fall back to a write.
			found = 1'b0;
			for (int t = 0; t < 16 && !found; t++) begin
				addr = ($urandom_range(7) == 0) ? 10'($urandom) :
					10'($urandom_range(FOCUS - 1));
				found = sb.written[addr];
			end
			if (found)
				req_op = OP_READ;
		end else if (pick < 95) begin
			req_op = OP_ROTATE;
			if ($urandom_range(4) != 0) begin
				// Well-formed move: block inside the span, destination on either side.
				span = ($urandom_range(24) == 0) ? DEPTH : FOCUS;
				n    = $urandom_range(1, (span == DEPTH) ? DEPTH - 1 : 12);
				s    = $urandom_range(0, span - n);
				src  = 10'(s);
				len  = 11'(n);
				if (s > 0 && $urandom_range(1) == 0)
					dst = 11'($urandom_range(0, s - 1));
				else
					dst = 11'($urandom_range(s + n, span));
			end
		end else begin
			req_op = OP_UNKNOWN;
		end
		issue_request(req_op, addr, data, dst, src, len);
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of the data and address, every op, every move outcome.
		sender_idle_pct = 18;
		issue_request(OP_WRITE, 10'd0, 32'hFFFF_FFFF, '0, '0, '0);
		issue_request(OP_WRITE, 10'd1023, 32'h0000_0000, '0, '0, '0);
		for (int i = 1; i < 8; i++)
			issue_request(OP_WRITE, 10'(i), 32'h5A00_0000 | (32'(i) << 8) | 32'(i),
				'0, '0, '0);
		issue_request(OP_READ, 10'd1023, '0, '0, '0, '0);
		issue_request(OP_UNKNOWN, 10'd3, 32'hDEAD_BEEF, 11'd5, 10'd2, 11'd1);
		// Empty block, source equal to destination, destination inside the block.
		issue_request(OP_ROTATE, '0, '0, 11'd5, 10'd2, 11'd0);
		issue_request(OP_ROTATE, '0, '0, 11'd3, 10'd3, 11'd2);
		issue_request(OP_ROTATE, '0, '0, 11'd3, 10'd1, 11'd4);
		// Destination past the end, block past the end.
		issue_request(OP_ROTATE, '0, '0, 11'd2047, 10'd0, 11'd1);
		issue_request(OP_ROTATE, '0, '0, 11'd0, 10'd1023, 11'd2);
		// Whole store as one block, moved to the very end: contents unchanged.
		issue_request(OP_ROTATE, '0, '0, 11'd1024, 10'd0, 11'd1024);
		// Move down, move up, destination right after the block, block to the end.
		issue_request(OP_ROTATE, '0, '0, 11'd1, 10'd4, 11'd3);
		issue_request(OP_ROTATE, '0, '0, 11'd6, 10'd0, 11'd2);
		issue_request(OP_ROTATE, '0, '0, 11'd5, 10'd2, 11'd3);
		issue_request(OP_ROTATE, '0, '0, 11'd1024, 10'd1000, 11'd4);
		for (int i = 0; i < 6; i++)
			issue_request(OP_READ, 10'(i), '0, '0, '0, '0);

		// Random traffic: light sender gaps, heavy gaps, then back to back.
		for (int ph = 0; ph < 3; ph++) begin
			drain_results();
			sender_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 73 : 0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				random_item();
		end

		drain_results();
		// Catch any stray strobe after the last expected result word.
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("in_place_block_rotate_engine_tb: clean");
		else
			$display("in_place_block_rotate_engine_tb: errors");
		$finish;
	end

endmodule

@@ in_place_block_rotate_engine.f @@
design/ibre_pkg.sv
design/ibre_mem.sv
design/ibre_rot.sv
design/in_place_block_rotate_engine.sv
bench/in_place_block_rotate_engine_tb.sv
